[rtl/indel_left_align_global_aligner_core_macros.svh]
// assertion macros shared by the checker of the aligner core
// expects clk and rst_n in the scope where a macro is used
`ifndef INDEL_LEFT_ALIGN_GLOBAL_ALIGNER_CORE_MACROS_SVH
`define INDEL_LEFT_ALIGN_GLOBAL_ALIGNER_CORE_MACROS_SVH

// same-cycle implication
`define ILGA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ILGA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ilga_pkg.sv]
// shared types and constants of the indel left-align global aligner
// no dependencies
package ilga_pkg;

  localparam int MAX_LEN_DEF = 128;
  localparam int BASE_W      = 8;
  localparam int OUT_W       = 8;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_REF   = 2'd1,
    OP_ALT   = 2'd2,
    OP_ALIGN = 2'd3
  } op_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SMALL = 2'd1;
  localparam logic [1:0] STAT_OVF   = 2'd2;

  typedef enum logic [1:0] {
    DIR_M = 2'd0,
    DIR_I = 2'd1,
    DIR_D = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    REG_MATCH    = 3'd0,
    REG_MISMATCH = 3'd1,
    REG_GAP_OPEN = 3'd2,
    REG_GAP_EXT  = 3'd3,
    REG_GAP_CLS  = 3'd4,
    REG_CORNER   = 3'd5
  } reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_LD_RD,
    S_LD_EV,
    S_TB_RD,
    S_TB_EV,
    S_FIN_RD,
    S_FIN_EV
  } state_t;

  typedef struct packed {
    logic        [3:0] match;
    logic signed [4:0] mismatch;
    logic signed [4:0] gap_open;
    logic signed [4:0] gap_extend;
    logic signed [4:0] gap_close;
    logic        [7:0] corner;
  } score_cfg_t;

  typedef struct packed {
    op_t               op;
    logic [BASE_W-1:0] base;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OUT_W-1:0] diff_start;
    logic [OUT_W-1:0] ref_end;
    logic [OUT_W-1:0] alt_end;
  } out_item_t;

endpackage

[rtl/indel_left_align_global_aligner_core.sv]
// Indel left-align global aligner core.
// Input channel in_valid/in_ready/in_data carries one op per transfer: clear,
// append reference base, append alternate base, or align. Appends and clear
// give no result. An align gives one result on out_valid/out_ready/out_data
// (status, diff_start, ref_end, alt_end).
// An align first sends the score wave across the cell row (one antidiagonal
// per cycle), then walks the traceback, where each step waits on a
// registered read of a cell's direction memory. Overflow, or an empty
// sequence, answers straight from idle. The block takes one align at a time.
// A new op is refused while busy; clear and appends are taken while a result
// waits, an align waits until the result is taken. The result holds while
// out_ready is low. Reset (rst_n low, synchronous) empties both sequences,
// clears the overflow flag and restores the score registers; bases need no
// clearing since only written entries are ever read.
// Score registers sit on an APB-style port at byte address 4*index.
// depends on ilga_pkg, ilga_array
module indel_left_align_global_aligner_core #(
  parameter int MAX_LEN = ilga_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ilga_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ilga_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ilga_pkg::CFG_AW-1:0]   paddr,
  input  logic [ilga_pkg::CFG_DW-1:0]   pwdata,
  output logic [ilga_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int RW = $clog2(MAX_LEN+1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int SW = RW + 8;
  localparam int EW = RW + ilga_pkg::OUT_W;

  ilga_pkg::score_cfg_t cfg_r;
  ilga_pkg::state_t     state_r, state_nxt;

  logic [RW-1:0] ref_count_r, alt_count_r;
  logic          ovf_r;
  logic [ilga_pkg::BASE_W-1:0] alt_mem [MAX_LEN];
  logic [ilga_pkg::BASE_W-1:0] alt_q_r;
  logic [RW:0]   fcnt_r;
  logic [RW-1:0] i_r, j_r, ipos_r, nout_ref_r, nout_seq_r, nsuf_r;
  logic          out_valid_r;
  ilga_pkg::out_item_t out_r;

  logic          acc, is_align, cfg_wr;
  logic [RW:0]   fill_last;
  logic [RW-1:0] alt_idx, dpos, lref, lseq, dstart;
  logic [AW-1:0] alt_raddr, sel, rd_addr;
  logic          ld_cont, ld_exit, bump;
  logic          inj_valid;
  logic signed [SW-1:0] inj_diag;
  ilga_pkg::dir_t       sel_dir;
  logic [ilga_pkg::BASE_W-1:0] sel_ref;
  logic [EW-1:0] ext_d, ext_r, ext_s;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign is_align = (in_data.op == ilga_pkg::OP_ALIGN);
  assign in_ready = (state_r == ilga_pkg::S_IDLE) && !(out_valid_r && is_align);
  assign acc      = in_valid && in_ready;

  always_comb begin
    unique case (ilga_pkg::reg_t'(paddr[4:2]))
      ilga_pkg::REG_MATCH:    prdata = ilga_pkg::CFG_DW'(cfg_r.match);
      ilga_pkg::REG_MISMATCH: prdata = ilga_pkg::CFG_DW'(unsigned'(cfg_r.mismatch));
      ilga_pkg::REG_GAP_OPEN: prdata = ilga_pkg::CFG_DW'(unsigned'(cfg_r.gap_open));
      ilga_pkg::REG_GAP_EXT:  prdata = ilga_pkg::CFG_DW'(unsigned'(cfg_r.gap_extend));
      ilga_pkg::REG_GAP_CLS:  prdata = ilga_pkg::CFG_DW'(unsigned'(cfg_r.gap_close));
      ilga_pkg::REG_CORNER:   prdata = ilga_pkg::CFG_DW'(cfg_r.corner);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.match      <= 4'd1;
      cfg_r.mismatch   <= -5'sd1;
      cfg_r.gap_open   <= -5'sd1;
      cfg_r.gap_extend <= 5'sd0;
      cfg_r.gap_close  <= -5'sd1;
      cfg_r.corner     <= 8'd20;
    end else if (cfg_wr) begin
      case (ilga_pkg::reg_t'(paddr[4:2]))
        ilga_pkg::REG_MATCH:    cfg_r.match      <= pwdata[3:0];
        ilga_pkg::REG_MISMATCH: cfg_r.mismatch   <= pwdata[4:0];
        ilga_pkg::REG_GAP_OPEN: cfg_r.gap_open   <= pwdata[4:0];
        ilga_pkg::REG_GAP_EXT:  cfg_r.gap_extend <= pwdata[4:0];
        ilga_pkg::REG_GAP_CLS:  cfg_r.gap_close  <= pwdata[4:0];
        ilga_pkg::REG_CORNER:   cfg_r.corner     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // datapath helpers
  always_comb begin
    fill_last = {1'b0, alt_count_r} + {1'b0, ref_count_r} - (RW+1)'(1);
    inj_valid = (state_r == ilga_pkg::S_FILL) && (fcnt_r != '0)
                && (fcnt_r <= {1'b0, alt_count_r});
    inj_diag  = (fcnt_r == (RW+1)'(1)) ? SW'($signed({1'b0, cfg_r.corner})) : '0;
    ld_cont   = (ref_count_r > alt_count_r) ? (i_r > RW'(1)) : (j_r != '0);
    ld_exit   = ((state_r == ilga_pkg::S_LD_RD) && !ld_cont)
                || ((state_r == ilga_pkg::S_LD_EV) && (sel_dir != ilga_pkg::DIR_M));
    dpos      = ipos_r - RW'(1);
    lref      = nout_ref_r - nsuf_r;
    lseq      = nout_seq_r - nsuf_r;
    bump      = (lref > ipos_r) && (lseq > ipos_r) && (sel_ref == alt_q_r);
    dstart    = dpos + RW'(bump);
    ext_d     = EW'(dstart);
    ext_r     = EW'(lref);
    ext_s     = EW'(lseq);
    rd_addr   = AW'(i_r - RW'(1));
    if (state_r == ilga_pkg::S_FILL) begin
      alt_idx = alt_count_r - RW'(1) - fcnt_r[RW-1:0];
    end else if (state_r == ilga_pkg::S_FIN_RD) begin
      alt_idx = dpos;
    end else begin
      alt_idx = alt_count_r - i_r;
    end
    alt_raddr = alt_idx[AW-1:0];
    if (state_r == ilga_pkg::S_FIN_RD || state_r == ilga_pkg::S_FIN_EV) begin
      sel = dpos[AW-1:0];
    end else begin
      sel = AW'(ref_count_r - j_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ilga_pkg::S_IDLE: begin
        if (acc && is_align && !ovf_r && ref_count_r != '0 && alt_count_r != '0) begin
          state_nxt = ilga_pkg::S_FILL;
        end
      end
      ilga_pkg::S_FILL: begin
        if (fcnt_r == fill_last) state_nxt = ilga_pkg::S_LD_RD;
      end
      ilga_pkg::S_LD_RD, ilga_pkg::S_LD_EV: begin
        if (ld_exit) begin
          state_nxt = (ipos_r == '0) ? ilga_pkg::S_IDLE : ilga_pkg::S_TB_RD;
        end else begin
          state_nxt = (state_r == ilga_pkg::S_LD_RD) ? ilga_pkg::S_LD_EV : ilga_pkg::S_LD_RD;
        end
      end
      ilga_pkg::S_TB_RD: begin
        if (i_r == '0 && j_r == '0) state_nxt = ilga_pkg::S_FIN_RD;
        else if (i_r != '0 && j_r != '0) state_nxt = ilga_pkg::S_TB_EV;
      end
      ilga_pkg::S_TB_EV:  state_nxt = ilga_pkg::S_TB_RD;
      ilga_pkg::S_FIN_RD: state_nxt = ilga_pkg::S_FIN_EV;
      ilga_pkg::S_FIN_EV: state_nxt = ilga_pkg::S_IDLE;
      default:            state_nxt = ilga_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ilga_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequence counts, overflow flag and result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_count_r <= '0;
      alt_count_r <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (acc) begin
        case (in_data.op)
          ilga_pkg::OP_CLEAR: begin
            ref_count_r <= '0;
            alt_count_r <= '0;
            ovf_r       <= 1'b0;
          end
          ilga_pkg::OP_REF: begin
            if (ref_count_r < RW'(MAX_LEN)) ref_count_r <= ref_count_r + RW'(1);
            else ovf_r <= 1'b1;
          end
          ilga_pkg::OP_ALT: begin
            if (alt_count_r < RW'(MAX_LEN)) alt_count_r <= alt_count_r + RW'(1);
            else ovf_r <= 1'b1;
          end
          default: begin
            if (ovf_r || ref_count_r == '0 || alt_count_r == '0) begin
              out_valid_r <= 1'b1;
              alt_count_r <= '0;
            end
          end
        endcase
      end
      if (ld_exit && ipos_r == '0) begin
        out_valid_r <= 1'b1;
        alt_count_r <= '0;
      end
      if (state_r == ilga_pkg::S_FIN_EV) begin
        out_valid_r <= 1'b1;
        alt_count_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_data.op == ilga_pkg::OP_ALT && alt_count_r < RW'(MAX_LEN)) begin
      alt_mem[alt_count_r[AW-1:0]] <= in_data.base;
    end
    alt_q_r <= alt_mem[alt_raddr];
  end

  // fill counter, traceback and result registers
  always_ff @(posedge clk) begin
    case (state_r)
      ilga_pkg::S_IDLE: begin
        fcnt_r <= '0;
        if (acc && is_align) begin
          out_r.status     <= ovf_r ? ilga_pkg::STAT_OVF : ilga_pkg::STAT_SMALL;
          out_r.diff_start <= '0;
          out_r.ref_end    <= '0;
          out_r.alt_end    <= '0;
        end
      end
      ilga_pkg::S_FILL: begin
        fcnt_r <= fcnt_r + (RW+1)'(1);
        i_r    <= alt_count_r;
        j_r    <= ref_count_r;
        ipos_r <= '0;
      end
      ilga_pkg::S_LD_RD, ilga_pkg::S_LD_EV: begin
        if (ld_exit) begin
          nout_ref_r <= ipos_r;
          nout_seq_r <= ipos_r;
          nsuf_r     <= '0;
        end else if (state_r == ilga_pkg::S_LD_EV) begin
          i_r    <= i_r - RW'(1);
          j_r    <= j_r - RW'(1);
          ipos_r <= ipos_r + RW'(1);
        end
      end
      ilga_pkg::S_TB_RD: begin
        if (j_r == '0 && i_r != '0) begin
          nsuf_r     <= '0;
          nout_seq_r <= nout_seq_r + RW'(1);
          i_r        <= i_r - RW'(1);
        end else if (i_r == '0 && j_r != '0) begin
          nsuf_r     <= '0;
          nout_ref_r <= nout_ref_r + RW'(1);
          j_r        <= j_r - RW'(1);
        end
      end
      ilga_pkg::S_TB_EV: begin
        if (sel_dir == ilga_pkg::DIR_I) begin
          nsuf_r     <= '0;
          nout_seq_r <= nout_seq_r + RW'(1);
          i_r        <= i_r - RW'(1);
        end else if (sel_dir == ilga_pkg::DIR_D) begin
          nsuf_r     <= '0;
          nout_ref_r <= nout_ref_r + RW'(1);
          j_r        <= j_r - RW'(1);
        end else begin
          nsuf_r     <= (sel_ref == alt_q_r) ? nsuf_r + RW'(1) : '0;
          nout_seq_r <= nout_seq_r + RW'(1);
          nout_ref_r <= nout_ref_r + RW'(1);
          i_r        <= i_r - RW'(1);
          j_r        <= j_r - RW'(1);
        end
      end
      ilga_pkg::S_FIN_EV: begin
        out_r.status     <= ilga_pkg::STAT_OK;
        out_r.diff_start <= ext_d[ilga_pkg::OUT_W-1:0];
        out_r.ref_end    <= ext_r[ilga_pkg::OUT_W-1:0];
        out_r.alt_end    <= ext_s[ilga_pkg::OUT_W-1:0];
      end
      default: ;
    endcase
    if (ld_exit && ipos_r == '0) begin
      out_r.status     <= ilga_pkg::STAT_SMALL;
      out_r.diff_start <= '0;
      out_r.ref_end    <= '0;
      out_r.alt_end    <= '0;
    end
  end

  ilga_array #(
    .MAX_LEN (MAX_LEN)
  ) u_array (
    .clk       (clk),
    .rst_n     (rst_n),
    .init      (acc && is_align),
    .cfg       (cfg_r),
    .nref      (ref_count_r),
    .ld_en     (acc && in_data.op == ilga_pkg::OP_REF && ref_count_r < RW'(MAX_LEN)),
    .ld_idx    (ref_count_r[AW-1:0]),
    .ld_base   (in_data.base),
    .inj_valid (inj_valid),
    .inj_row   (fcnt_r[RW-1:0]),
    .inj_alt   (alt_q_r),
    .inj_diag  (inj_diag),
    .rd_addr   (rd_addr),
    .sel       (sel),
    .sel_dir   (sel_dir),
    .sel_ref   (sel_ref)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/ilga_cell.sv]
// one column cell of the systolic score array: holds a reference base,
// the last score of its column and the column's direction memory; uses ilga_pkg
module ilga_cell #(
  parameter int MAX_LEN = ilga_pkg::MAX_LEN_DEF,
  parameter int K       = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            init,
  input  ilga_pkg::score_cfg_t            cfg,
  input  logic [$clog2(MAX_LEN+1)-1:0]    nref,
  input  logic                            ld_en,
  input  logic [$clog2(MAX_LEN)-1:0]      ld_idx,
  input  logic [ilga_pkg::BASE_W-1:0]     ld_base,
  input  logic                            fi_valid,
  input  logic [$clog2(MAX_LEN+1)-1:0]    fi_row,
  input  logic [ilga_pkg::BASE_W-1:0]     fi_alt,
  input  logic signed [$clog2(MAX_LEN+1)+7:0] fi_left,
  input  ilga_pkg::dir_t                  fi_left_dir,
  input  logic signed [$clog2(MAX_LEN+1)+7:0] fi_diag,
  input  ilga_pkg::dir_t                  fi_diag_dir,
  output logic                            fo_valid,
  output logic [$clog2(MAX_LEN+1)-1:0]    fo_row,
  output logic [ilga_pkg::BASE_W-1:0]     fo_alt,
  output logic signed [$clog2(MAX_LEN+1)+7:0] fo_left,
  output ilga_pkg::dir_t                  fo_left_dir,
  output logic signed [$clog2(MAX_LEN+1)+7:0] fo_diag,
  output ilga_pkg::dir_t                  fo_diag_dir,
  input  logic [$clog2(MAX_LEN)-1:0]      rd_addr,
  output ilga_pkg::dir_t                  rd_dir,
  output logic [ilga_pkg::BASE_W-1:0]     ref_base
);

  localparam int RW = $clog2(MAX_LEN+1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int SW = RW + 8;

  logic signed [SW-1:0]        up_score_r, diag_score_r;
  ilga_pkg::dir_t              up_dir_r, diag_dir_r;
  logic                        valid_r;
  logic [RW-1:0]               row_r;
  logic [ilga_pkg::BASE_W-1:0] alt_r, ref_r;
  ilga_pkg::dir_t              mem [MAX_LEN];
  ilga_pkg::dir_t              rd_dir_r;

  logic [RW-1:0]        col_j;
  logic                 eq, lower;
  logic signed [SW-1:0] w_match, w_mism, w_open, w_ext, w_close;
  logic signed [SW-1:0] sdiag, sins, sdel;
  logic signed [SW-1:0] c0, c1, c2, best;
  ilga_pkg::dir_t       d0, d1, d2, bdir;

  always_comb begin
    col_j   = nref - RW'(K);
    eq      = (ref_r == fi_alt);
    lower   = (col_j < fi_row);
    w_match = SW'($signed({1'b0, cfg.match}));
    w_mism  = SW'(cfg.mismatch);
    w_open  = SW'(cfg.gap_open);
    w_ext   = SW'(cfg.gap_extend);
    w_close = SW'(cfg.gap_close);
    sdiag   = fi_diag + (eq ? w_match : w_mism)
              + ((fi_diag_dir != ilga_pkg::DIR_M) ? w_close : SW'(0));
    sins    = up_score_r + ((up_dir_r == ilga_pkg::DIR_I) ? w_ext : w_open);
    sdel    = fi_left + ((fi_left_dir == ilga_pkg::DIR_D) ? w_ext : w_open);
    // tie order leans to insertions below the diagonal, deletions on and above
    if (eq) begin
      c0 = sdiag; d0 = ilga_pkg::DIR_M;
      if (lower) begin
        c1 = sins; d1 = ilga_pkg::DIR_I; c2 = sdel; d2 = ilga_pkg::DIR_D;
      end else begin
        c1 = sdel; d1 = ilga_pkg::DIR_D; c2 = sins; d2 = ilga_pkg::DIR_I;
      end
    end else begin
      if (lower) begin
        c0 = sins; d0 = ilga_pkg::DIR_I; c1 = sdel; d1 = ilga_pkg::DIR_D;
      end else begin
        c0 = sdel; d0 = ilga_pkg::DIR_D; c1 = sins; d1 = ilga_pkg::DIR_I;
      end
      c2 = sdiag; d2 = ilga_pkg::DIR_M;
    end
    best = c0;
    bdir = d0;
    if (best < c1) begin
      best = c1; bdir = d1;
    end
    if (best < c2) begin
      best = c2; bdir = d2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= fi_valid && !init;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_en && (ld_idx == AW'(K))) begin
      ref_r <= ld_base;
    end
    if (init) begin
      up_score_r <= '0;
      up_dir_r   <= ilga_pkg::DIR_M;
    end else if (fi_valid) begin
      up_score_r   <= best;
      up_dir_r     <= bdir;
      diag_score_r <= up_score_r;
      diag_dir_r   <= up_dir_r;
      row_r        <= fi_row;
      alt_r        <= fi_alt;
    end
  end

  // direction memory of this column, one row per address
  always_ff @(posedge clk) begin
    if (fi_valid && !init) begin
      mem[AW'(fi_row - RW'(1))] <= bdir;
    end
    rd_dir_r <= mem[rd_addr];
  end

  assign fo_valid    = valid_r;
  assign fo_row      = row_r;
  assign fo_alt      = alt_r;
  assign fo_left     = up_score_r;
  assign fo_left_dir = up_dir_r;
  assign fo_diag     = diag_score_r;
  assign fo_diag_dir = diag_dir_r;
  assign rd_dir      = rd_dir_r;
  assign ref_base    = ref_r;

endmodule

[rtl/ilga_array.sv]
// row of score cells; rows enter at the cell of column one and
// sweep toward the window start one column per cycle; uses ilga_pkg, ilga_cell
module ilga_array #(
  parameter int MAX_LEN = ilga_pkg::MAX_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                init,
  input  ilga_pkg::score_cfg_t                cfg,
  input  logic [$clog2(MAX_LEN+1)-1:0]        nref,
  input  logic                                ld_en,
  input  logic [$clog2(MAX_LEN)-1:0]          ld_idx,
  input  logic [ilga_pkg::BASE_W-1:0]         ld_base,
  input  logic                                inj_valid,
  input  logic [$clog2(MAX_LEN+1)-1:0]        inj_row,
  input  logic [ilga_pkg::BASE_W-1:0]         inj_alt,
  input  logic signed [$clog2(MAX_LEN+1)+7:0] inj_diag,
  input  logic [$clog2(MAX_LEN)-1:0]          rd_addr,
  input  logic [$clog2(MAX_LEN)-1:0]          sel,
  output ilga_pkg::dir_t                      sel_dir,
  output logic [ilga_pkg::BASE_W-1:0]         sel_ref
);

  localparam int RW = $clog2(MAX_LEN+1);
  localparam int SW = RW + 8;

  logic                        fo_valid    [MAX_LEN];
  logic [RW-1:0]               fo_row      [MAX_LEN];
  logic [ilga_pkg::BASE_W-1:0] fo_alt      [MAX_LEN];
  logic signed [SW-1:0]        fo_left     [MAX_LEN];
  ilga_pkg::dir_t              fo_left_dir [MAX_LEN];
  logic signed [SW-1:0]        fo_diag     [MAX_LEN];
  ilga_pkg::dir_t              fo_diag_dir [MAX_LEN];
  ilga_pkg::dir_t              cell_dir    [MAX_LEN];
  logic [ilga_pkg::BASE_W-1:0] cell_ref    [MAX_LEN];

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    logic                        fi_valid;
    logic [RW-1:0]               fi_row;
    logic [ilga_pkg::BASE_W-1:0] fi_alt;
    logic signed [SW-1:0]        fi_left, fi_diag;
    ilga_pkg::dir_t              fi_left_dir, fi_diag_dir;
    logic                        at_edge;

    // column one of the current window takes the new row from the edge
    assign at_edge = (nref == RW'(k + 1));

    if (k == MAX_LEN - 1) begin : g_top
      always_comb begin
        fi_valid    = at_edge && inj_valid;
        fi_row      = inj_row;
        fi_alt      = inj_alt;
        fi_left     = '0;
        fi_left_dir = ilga_pkg::DIR_M;
        fi_diag     = inj_diag;
        fi_diag_dir = ilga_pkg::DIR_M;
      end
    end else begin : g_mid
      always_comb begin
        if (at_edge) begin
          fi_valid    = inj_valid;
          fi_row      = inj_row;
          fi_alt      = inj_alt;
          fi_left     = '0;
          fi_left_dir = ilga_pkg::DIR_M;
          fi_diag     = inj_diag;
          fi_diag_dir = ilga_pkg::DIR_M;
        end else begin
          fi_valid    = fo_valid[k+1];
          fi_row      = fo_row[k+1];
          fi_alt      = fo_alt[k+1];
          fi_left     = fo_left[k+1];
          fi_left_dir = fo_left_dir[k+1];
          fi_diag     = fo_diag[k+1];
          fi_diag_dir = fo_diag_dir[k+1];
        end
      end
    end

    ilga_cell #(
      .MAX_LEN (MAX_LEN),
      .K       (k)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .init        (init),
      .cfg         (cfg),
      .nref        (nref),
      .ld_en       (ld_en),
      .ld_idx      (ld_idx),
      .ld_base     (ld_base),
      .fi_valid    (fi_valid),
      .fi_row      (fi_row),
      .fi_alt      (fi_alt),
      .fi_left     (fi_left),
      .fi_left_dir (fi_left_dir),
      .fi_diag     (fi_diag),
      .fi_diag_dir (fi_diag_dir),
      .fo_valid    (fo_valid[k]),
      .fo_row      (fo_row[k]),
      .fo_alt      (fo_alt[k]),
      .fo_left     (fo_left[k]),
      .fo_left_dir (fo_left_dir[k]),
      .fo_diag     (fo_diag[k]),
      .fo_diag_dir (fo_diag_dir[k]),
      .rd_addr     (rd_addr),
      .rd_dir      (cell_dir[k]),
      .ref_base    (cell_ref[k])
    );
  end

  assign sel_dir = cell_dir[sel];
  assign sel_ref = cell_ref[sel];

endmodule

[rtl/ilga_checker.sv]
// port-level checks of the aligner core, bound to the top level
// depends on ilga_pkg and indel_left_align_global_aligner_core_macros.svh
`include "indel_left_align_global_aligner_core_macros.svh"

module ilga_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input ilga_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input ilga_pkg::out_item_t out_data
);

  // a waiting result is not dropped
  `ILGA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // an align is held off while a result still waits
  `ILGA_ASSERT_IMP(a_align_blocked, out_valid && in_valid && in_data.op == ilga_pkg::OP_ALIGN, !in_ready, "align taken while result pending")

  // clear and append never produce a result
  `ILGA_ASSERT_NXT(a_no_extra_out, in_valid && in_ready && in_data.op != ilga_pkg::OP_ALIGN && !out_valid, !out_valid, "result without align")

  // failed alignments report zero positions
  `ILGA_ASSERT_IMP(a_fail_zero, out_valid && out_data.status != ilga_pkg::STAT_OK, out_data.diff_start == 8'd0 && out_data.ref_end == 8'd0 && out_data.alt_end == 8'd0, "nonzero fields on failed align")

endmodule

bind indel_left_align_global_aligner_core ilga_checker u_ilga_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[sim/indel_left_align_global_aligner_core_checker.sv]
// checker for the aligner core: watches the input, result and register ports,
// predicts each align result and compares it field by field
// depends on ilga_pkg
module indel_left_align_global_aligner_core_checker
  import ilga_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  input  logic                pready,
  output int                  errors,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEQ_MAX = MAX_LEN_DEF;
  localparam int NC = SEQ_MAX + 1;

  logic [7:0] ref_bases [SEQ_MAX];
  logic [7:0] alt_bases [SEQ_MAX];
  int         ref_len;
  int         alt_len;
  bit         ovf;
  dir_t       trace [NC*NC];
  int         row_score [2][NC];
  int         sc_match, sc_mism, sc_open, sc_ext, sc_close, sc_corner;
  out_item_t  expected_align [$];

  assign pending = expected_align.size();

  function automatic int sx5(logic [4:0] v);
    return $signed(v);
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic score_matrix(int nref, int nseq);
    int up, cu, sd, si, sl, best;
    int c [3];
    dir_t d [3];
    dir_t bd;
    bit eq, lower;
    row_score[0][0] = sc_corner;
    trace[0] = DIR_M;
    for (int j = 1; j <= nref; j++) begin
      row_score[0][j] = 0;
      trace[j] = DIR_M;
    end
    for (int i = 1; i <= nseq; i++) begin
      up = (i - 1) & 1;
      cu = i & 1;
      row_score[cu][0] = 0;
      trace[i*NC] = DIR_M;
      for (int j = 1; j <= nref; j++) begin
        eq = ref_bases[nref-j] == alt_bases[nseq-i];
        lower = j < i;
        sd = row_score[up][j-1] + (eq ? sc_match : sc_mism)
             + (trace[(i-1)*NC+j-1] != DIR_M ? sc_close : 0);
        si = row_score[up][j] + (trace[(i-1)*NC+j] == DIR_I ? sc_ext : sc_open);
        sl = row_score[cu][j-1] + (trace[i*NC+j-1] == DIR_D ? sc_ext : sc_open);
        if (eq) begin
          c[0] = sd; d[0] = DIR_M;
          if (lower) begin
            c[1] = si; d[1] = DIR_I; c[2] = sl; d[2] = DIR_D;
          end else begin
            c[1] = sl; d[1] = DIR_D; c[2] = si; d[2] = DIR_I;
          end
        end else begin
          if (lower) begin
            c[0] = si; d[0] = DIR_I; c[1] = sl; d[1] = DIR_D;
          end else begin
            c[0] = sl; d[0] = DIR_D; c[1] = si; d[1] = DIR_I;
          end
          c[2] = sd; d[2] = DIR_M;
        end
        best = c[0];
        bd = d[0];
        for (int k = 1; k < 3; k++)
          if (best < c[k]) begin
            best = c[k];
            bd = d[k];
          end
        row_score[cu][j] = best;
        trace[i*NC+j] = bd;
      end
    end
  endtask

  task automatic predict_align(output out_item_t r);
    int nref, nseq, i, j, run, oref, oseq, suffix, dpos, lref, lseq;
    dir_t dd;
    r = '0;
    nref = ref_len;
    nseq = alt_len;
    run = 0;
    suffix = 0;
    if (ovf) begin
      r.status = STAT_OVF;
      return;
    end
    score_matrix(nref, nseq);
    i = nseq;
    j = nref;
    if (nref > 0 && nseq > 0)
      while (((nref > nseq) ? (i > 1) : (j > 0)) && trace[i*NC+j] == DIR_M) begin
        i--; j--; run++;
      end
    if (run == 0) begin
      r.status = STAT_SMALL;
      return;
    end
    oref = run;
    oseq = run;
    while (i > 0 || j > 0) begin
      dd = trace[i*NC+j];
      if (j == 0 || dd == DIR_I) begin
        suffix = 0; oseq++; i--;
      end else if (i == 0 || dd == DIR_D) begin
        suffix = 0; oref++; j--;
      end else begin
        suffix = (ref_bases[nref-j] == alt_bases[nseq-i]) ? suffix + 1 : 0;
        oseq++; oref++; i--; j--;
      end
    end
    dpos = run - 1;
    lref = oref - suffix;
    lseq = oseq - suffix;
    // complex event: drop the padding base
    if (lref > dpos + 1 && lseq > dpos + 1 && ref_bases[dpos] == alt_bases[dpos])
      dpos++;
    r.status = STAT_OK;
    r.diff_start = dpos[7:0];
    r.ref_end = lref[7:0];
    r.alt_end = lseq[7:0];
  endtask

  always @(posedge clk) begin
    out_item_t r, want;
    if (!rst_n) begin
      ref_len = 0; alt_len = 0; ovf = 0;
      sc_match = 1; sc_mism = -1; sc_open = -1; sc_ext = 0; sc_close = -1; sc_corner = 20;
      expected_align.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready)
        case (reg_t'(paddr[4:2]))
          REG_MATCH:    sc_match = pwdata[3:0];
          REG_MISMATCH: sc_mism = sx5(pwdata[4:0]);
          REG_GAP_OPEN: sc_open = sx5(pwdata[4:0]);
          REG_GAP_EXT:  sc_ext = sx5(pwdata[4:0]);
          REG_GAP_CLS:  sc_close = sx5(pwdata[4:0]);
          REG_CORNER:   sc_corner = pwdata[7:0];
          default: ;
        endcase
      if (in_valid && in_ready)
        case (in_data.op)
          OP_CLEAR: begin
            ref_len = 0; alt_len = 0; ovf = 0;
          end
          OP_REF: begin
            if (ref_len < SEQ_MAX) begin
              ref_bases[ref_len] = in_data.base;
              ref_len++;
            end else ovf = 1;
          end
          OP_ALT: begin
            if (alt_len < SEQ_MAX) begin
              alt_bases[alt_len] = in_data.base;
              alt_len++;
            end else ovf = 1;
          end
          default: begin
            predict_align(r);
            expected_align.push_back(r);
            alt_len = 0;
          end
        endcase
      if (out_valid && out_ready) begin
        if (expected_align.size() == 0) begin
          $display("result transfer with nothing expected at %0t", $realtime);
          errors++;
        end else begin
          want = expected_align.pop_front();
          if (out_data.status !== want.status) report("status", out_data.status, want.status);
          if (out_data.diff_start !== want.diff_start)
            report("diff_start", out_data.diff_start, want.diff_start);
          if (out_data.ref_end !== want.ref_end) report("ref_end", out_data.ref_end, want.ref_end);
          if (out_data.alt_end !== want.alt_end) report("alt_end", out_data.alt_end, want.alt_end);
        end
      end
    end
  end

endmodule

[sim/indel_left_align_global_aligner_core_test.sv]
// stimulus and verdict for the aligner core: loads sequence pairs under
// several score settings with random idling on both channels
// depends on ilga_pkg, the core and indel_left_align_global_aligner_core_checker
module indel_left_align_global_aligner_core_test;
  import ilga_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk = 0;
  logic                rst_n = 0;
  logic                in_valid = 0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 0;
  out_item_t           out_data;
  logic                psel = 0;
  logic                penable = 0;
  logic                pwrite = 0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [CFG_DW-1:0]   pwdata = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;
  int                  errors;
  int                  pending;
  bit                  calm = 0;
  bit                  hold_req = 0;
  int                  sent = 0;
  logic [7:0]          cur_ref [$];

  always #10 clk = ~clk;

  indel_left_align_global_aligner_core i_dut (.*);

  indel_left_align_global_aligner_core_checker i_check (.*);

  initial begin
    #200ms;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold = 600;
      end
      if (hold > 0) begin
        hold--;
        out_ready = 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 13);
        out_ready = 0;
      end else out_ready = 1;
    end
  end

  task automatic put(op_t op, logic [7:0] b);
    @(negedge clk);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid = 1;
    in_data = '{op: op, base: b};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic reg_write(reg_t idx, int val);
    @(negedge clk);
    in_valid = 0;
    psel = 1; pwrite = 1; penable = 0;
    paddr = CFG_AW'(int'(idx) * 4);
    pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 0;
    wait (pending == 0);
    repeat (30) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_base();
    logic [7:0] acgt [4] = '{8'h41, 8'h43, 8'h47, 8'h54};
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    return acgt[$urandom_range(0, 3)];
  endfunction

  // one case: optional new reference, an edited or empty alternate, an optional random op, then align
  task automatic run_case();
    int rl, n;
    if (cur_ref.size() == 0 || $urandom_range(0, 2) != 0) begin
      put(OP_CLEAR, $urandom_range(0, 255));
      cur_ref.delete();
      rl = ($urandom_range(0, 39) == 0) ? $urandom_range(100, 130) : $urandom_range(0, 14);
      repeat (rl) begin
        cur_ref.push_back(pick_base());
        put(OP_REF, cur_ref[$]);
      end
    end
    n = 0;
    if ($urandom_range(0, 19) != 0)
      foreach (cur_ref[k]) begin
        case ($urandom_range(0, 19))
          0: put(OP_ALT, pick_base());
          1: ;
          2: begin
            put(OP_ALT, pick_base());
            put(OP_ALT, cur_ref[k]);
          end
          default: put(OP_ALT, cur_ref[k]);
        endcase
      end
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) put(OP_ALT, pick_base());
    if ($urandom_range(0, 15) == 0) put(op_t'($urandom_range(0, 3)), $urandom_range(0, 255));
    put(OP_ALIGN, $urandom_range(0, 255));
  endtask

  initial begin
    int sets [6][6] = '{
      '{1, -1, -1, 0, -1, 20},
      '{15, -15, -15, -15, -15, 255},
      '{0, 0, 0, 0, 0, 0},
      '{15, 0, -15, 0, -15, 0},
      '{3, -4, -6, -1, -2, 128},
      '{0, -15, 0, -15, 0, 255}};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // directed: empty align and extreme bytes
    put(OP_ALIGN, 8'h00);
    put(OP_REF, 8'h00);
    put(OP_REF, 8'hFF);
    put(OP_ALIGN, 8'hFF);
    put(OP_ALT, 8'h00);
    put(OP_ALT, 8'hFF);
    put(OP_ALIGN, 8'h5A);
    put(OP_ALT, 8'h00);
    put(OP_ALT, 8'hFF);
    put(OP_ALT, 8'h00);
    put(OP_ALIGN, 8'hA5);
    put(OP_ALT, 8'hFF);
    put(OP_ALIGN, 8'h00);
    put(OP_CLEAR, 8'hFF);
    put(OP_REF, 8'h41);
    put(OP_ALT, 8'h43);
    put(OP_ALIGN, 8'h00);
    put(OP_ALT, 8'h41);
    put(OP_ALT, 8'h41);
    put(OP_ALIGN, 8'h00);
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      for (int r = 0; r < 6; r++) reg_write(reg_t'(r), sets[p][r]);
      cur_ref.delete();
      if (p == 5) calm = 1;
      while (sent < 230 * (p + 1) + 20) begin
        if (p == 1 && sent > 400 && sent < 420) hold_req = 1;
        run_case();
      end
    end
    // overflow of the reference store, then of the alternate store
    put(OP_CLEAR, 8'h00);
    repeat (129) put(OP_REF, 8'h47);
    put(OP_ALIGN, 8'h00);
    put(OP_CLEAR, 8'h00);
    put(OP_REF, 8'h47);
    repeat (129) put(OP_ALT, 8'h47);
    put(OP_ALIGN, 8'h00);
    put(OP_ALIGN, 8'h00);
    @(negedge clk);
    in_valid = 0;
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/ilga_pkg.sv
rtl/ilga_cell.sv
rtl/ilga_array.sv
rtl/indel_left_align_global_aligner_core.sv
rtl/ilga_checker.sv
sim/indel_left_align_global_aligner_core_checker.sv
sim/indel_left_align_global_aligner_core_test.sv
